### rtl/core/gcs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes of the grid cell shuffler.
// No dependencies; every other file imports this package.
package gcs_pkg;

  // Grid limits and the storage that follows from them.
  localparam int unsigned MAX_COLS  = 32;
  localparam int unsigned MAX_ROWS  = 32;
  localparam int unsigned LIST_SIZE = MAX_COLS * MAX_ROWS;
  localparam int unsigned COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ENTRY_W   = COL_W + ROW_W;
  localparam int unsigned IDX_W     = $clog2(LIST_SIZE);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned DIMC_W    = $clog2(MAX_COLS + 1);
  localparam int unsigned DIMR_W    = $clog2(MAX_ROWS + 1);

  // Fixed field widths of the ports.
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned SIDX_W    = 10;
  localparam int unsigned CELL_W    = 5;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd1;

  typedef enum logic [ACT_W-1:0] {
    ACT_BUILD   = 2'd0,
    ACT_SWAP    = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NEXT    = 2'd3
  } action_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SIDX_W-1:0] swap_index;
  } in_req_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic [POS_W-1:0]  read_position;
    logic              bad_index;
  } out_rsp_t;

  // Access to the cell list memory.
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

endpackage

### rtl/core/grid_cell_shuffler.sv
`timescale 1ns / 1ps
// Grid cell shuffler: one request in work at a time; its result goes out through an output register.
// The single read port of the list memory sets the swap: two reads then two writes.
// A new request is taken only once the result of the last one is registered.
// Reset clears control state and positions; the cell list holds garbage until the first build.
// Depends on gcs_pkg, gcs_list_ram and gcs_ctrl.
module grid_cell_shuffler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  gcs_pkg::in_req_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output gcs_pkg::out_rsp_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [gcs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gcs_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import gcs_pkg::*;

  logic [CFG_W-1:0]   cols_q, rows_q;
  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               res_valid, res_ready;
  out_rsp_t           res;
  logic               out_valid_q;
  out_rsp_t           out_q;

  // Grid size registers; they take effect at the next build.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= CFG_W'(32);
      rows_q <= CFG_W'(32);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLS: cols_q <= cfg_wdata_i;
        CFG_ROWS: rows_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  gcs_list_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  gcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cols_i      (cols_q),
    .rows_i      (rows_q),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: load when empty or being drained, hold while stalled.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/gcs_list_ram.sv
`timescale 1ns / 1ps
// Cell list memory: one write port, one read port, registered read data.
// Depends on gcs_pkg.
module gcs_list_ram (
  input  logic                      clk_i,
  input  gcs_pkg::ram_req_t         req_i,
  output logic [gcs_pkg::ENTRY_W-1:0] rdata_o
);
  import gcs_pkg::*;

  logic [ENTRY_W-1:0] mem [LIST_SIZE];
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/gcs_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the grid cell shuffler: build, swap, restart and next over the list memory.
// Depends on gcs_pkg.
module gcs_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  gcs_pkg::in_req_t            in_data_i,
  input  logic [gcs_pkg::CFG_W-1:0]   cols_i,
  input  logic [gcs_pkg::CFG_W-1:0]   rows_i,
  output gcs_pkg::ram_req_t           ram_req_o,
  input  logic [gcs_pkg::ENTRY_W-1:0] ram_rdata_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output gcs_pkg::out_rsp_t           res_o
);
  import gcs_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_BUILD = 7'b0000010,
    ST_RD_B  = 7'b0000100,
    ST_WR_A  = 7'b0001000,
    ST_WR_B  = 7'b0010000,
    ST_NEXT  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   shuf_q, shuf_d;
  logic [IDX_W-1:0]   rdpos_q, rdpos_d;
  logic [IDX_W-1:0]   bld_idx_q, bld_idx_d;
  logic [COL_W-1:0]   bx_q, bx_d;
  logic [ROW_W-1:0]   by_q, by_d;
  logic [DIMC_W-1:0]  nc_q, nc_d;
  logic [SIDX_W-1:0]  sidx_q, sidx_d;
  logic [ENTRY_W-1:0] tmp_q, tmp_d;
  logic [CELL_W-1:0]  res_x_q, res_x_d, res_y_q, res_y_d;
  logic               res_bad_q, res_bad_d;

  logic               accept;
  logic [DIMC_W-1:0]  nc_cl;
  logic [DIMR_W-1:0]  nr_cl;
  logic [IDX_W-1:0]   nx_pos;
  logic [CNT_W-1:0]   nx_inc;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  // Clamp the grid size to 1 .. maximum.
  always_comb begin
    if (cols_i == '0) begin
      nc_cl = DIMC_W'(1);
    end else if (32'(cols_i) > MAX_COLS) begin
      nc_cl = DIMC_W'(MAX_COLS);
    end else begin
      nc_cl = DIMC_W'(cols_i);
    end
    if (rows_i == '0) begin
      nr_cl = DIMR_W'(1);
    end else if (32'(rows_i) > MAX_ROWS) begin
      nr_cl = DIMR_W'(MAX_ROWS);
    end else begin
      nr_cl = DIMR_W'(rows_i);
    end
  end

  // Readout position, rewound when it lies past the end of the list.
  assign nx_pos = (CNT_W'(rdpos_q) >= count_q) ? '0 : rdpos_q;
  assign nx_inc = CNT_W'(nx_pos) + CNT_W'(1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    shuf_d    = shuf_q;
    rdpos_d   = rdpos_q;
    bld_idx_d = bld_idx_q;
    bx_d      = bx_q;
    by_d      = by_q;
    nc_d      = nc_q;
    sidx_d    = sidx_q;
    tmp_d     = tmp_q;
    res_x_d   = res_x_q;
    res_y_d   = res_y_q;
    res_bad_d = res_bad_q;
    ram_req_o = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_x_d   = '0;
          res_y_d   = '0;
          res_bad_d = 1'b0;
          sidx_d    = in_data_i.swap_index;
          case (action_e'(in_data_i.action))
            ACT_BUILD: begin
              nc_d      = nc_cl;
              count_d   = CNT_W'(nc_cl) * CNT_W'(nr_cl);
              shuf_d    = '0;
              bld_idx_d = '0;
              bx_d      = '0;
              by_d      = '0;
              state_d   = ST_BUILD;
            end
            ACT_SWAP: begin
              if (32'(in_data_i.swap_index) >= 32'(count_q) || shuf_q >= count_q) begin
                res_bad_d = 1'b1;
                state_d   = ST_DONE;
              end else begin
                ram_req_o.re    = 1'b1;
                ram_req_o.raddr = IDX_W'(shuf_q);
                state_d         = ST_RD_B;
              end
            end
            ACT_RESTART: begin
              rdpos_d = '0;
              state_d = ST_DONE;
            end
            default: begin
              if (count_q == '0) begin
                rdpos_d = '0;
                state_d = ST_DONE;
              end else begin
                ram_req_o.re    = 1'b1;
                ram_req_o.raddr = nx_pos;
                rdpos_d         = (nx_inc >= count_q) ? '0 : IDX_W'(nx_inc);
                state_d         = ST_NEXT;
              end
            end
          endcase
        end
      end
      ST_BUILD: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = bld_idx_q;
        ram_req_o.wdata = {by_q, bx_q};
        bld_idx_d       = bld_idx_q + IDX_W'(1);
        if (DIMC_W'(bx_q) + DIMC_W'(1) >= nc_q) begin
          bx_d = '0;
          by_d = by_q + ROW_W'(1);
        end else begin
          bx_d = bx_q + COL_W'(1);
        end
        if (CNT_W'(bld_idx_q) + CNT_W'(1) >= count_q) begin
          state_d = ST_DONE;
        end
      end
      ST_RD_B: begin
        // Hold entry A, fetch entry B.
        tmp_d           = ram_rdata_i;
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = IDX_W'(sidx_q);
        state_d         = ST_WR_A;
      end
      ST_WR_A: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = IDX_W'(shuf_q);
        ram_req_o.wdata = ram_rdata_i;
        state_d         = ST_WR_B;
      end
      ST_WR_B: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = IDX_W'(sidx_q);
        ram_req_o.wdata = tmp_q;
        shuf_d          = shuf_q + CNT_W'(1);
        state_d         = ST_DONE;
      end
      ST_NEXT: begin
        res_x_d = CELL_W'(ram_rdata_i[COL_W-1:0]);
        res_y_d = CELL_W'(ram_rdata_i[ENTRY_W-1:COL_W]);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      shuf_q    <= '0;
      rdpos_q   <= '0;
      bld_idx_q <= '0;
      bx_q      <= '0;
      by_q      <= '0;
      nc_q      <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      shuf_q    <= shuf_d;
      rdpos_q   <= rdpos_d;
      bld_idx_q <= bld_idx_d;
      bx_q      <= bx_d;
      by_q      <= by_d;
      nc_q      <= nc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sidx_q    <= sidx_d;
    tmp_q     <= tmp_d;
    res_x_q   <= res_x_d;
    res_y_q   <= res_y_d;
    res_bad_q <= res_bad_d;
  end

  assign in_stall_o          = (state_q != ST_IDLE);
  assign res_valid_o         = (state_q == ST_DONE);
  assign res_o.cell_x        = res_x_q;
  assign res_o.cell_y        = res_y_q;
  assign res_o.read_position = POS_W'(rdpos_q);
  assign res_o.bad_index     = res_bad_q;

endmodule

### rtl/core/gcs_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the grid cell shuffler, bound to the top level.
// Depends on gcs_pkg.
module gcs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input gcs_pkg::out_rsp_t             out_data_o
);
  import gcs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in work");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request in work");

  a_bad_no_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_index |-> out_data_o.cell_x == '0 && out_data_o.cell_y == '0)
    else $error("rejected swap returned a cell");

endmodule

bind grid_cell_shuffler gcs_checker u_gcs_checker (.*);

### bench/grid_cell_shuffler_test.sv
`timescale 1ns / 1ps
// Self-checking bench for grid_cell_shuffler: drives build, swap, restart and next requests
// and checks every result against its own copy of the cell list. Depends on gcs_pkg.
module grid_cell_shuffler_test;
  import gcs_pkg::*;

  // The slowest correct run is about 900 requests with a few dozen builds, random gaps on
  // both sides and one long hold-off.
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned IDLE_PCT    = 32;
  localparam int unsigned HOLD_CYCLES = 300;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_req_t              in_req    = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_rsp_t             out_rsp;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = CFG_COLS;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Stimulus control: calm turns off idling on both sides, hold_left holds off the receiver.
  bit          calm        = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count  = 0;

  // Shadow state of the shuffler: register copies, the cell list and its positions.
  logic [CFG_W-1:0]  cols_reg = CFG_W'(32);
  logic [CFG_W-1:0]  rows_reg = CFG_W'(32);
  logic [CELL_W-1:0] col_of [LIST_SIZE];
  logic [CELL_W-1:0] row_of [LIST_SIZE];
  int unsigned       shuf_pos = 0;
  int unsigned       read_pos = 0;
  int unsigned       n_cells  = 0;

  // Results still owed by the block, oldest first.
  out_rsp_t awaited_cells[$];

  grid_cell_shuffler dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted request to the shadow state and return the result it must produce.
  function automatic out_rsp_t predict_cell_result(in_req_t req);
    out_rsp_t          rsp;
    int unsigned       nc;
    int unsigned       nr;
    int unsigned       i;
    logic [CELL_W-1:0] tx;
    logic [CELL_W-1:0] ty;
    rsp = '0;
    case (req.action)
      ACT_BUILD: begin
        // A zero count means one; anything past the grid limit means the limit.
        nc = (cols_reg == 0) ? 1 : (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
        nr = (rows_reg == 0) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
        n_cells = nc * nr;
        for (i = 0; i < n_cells; i++) begin
          col_of[i] = CELL_W'(i % nc);
          row_of[i] = CELL_W'(i / nc);
        end
        // Rewind the shuffle but leave the readout where it is.
        shuf_pos = 0;
      end
      ACT_SWAP: begin
        if (req.swap_index >= n_cells || shuf_pos >= n_cells) begin
          rsp.bad_index = 1'b1;
        end else begin
          tx = col_of[shuf_pos];
          ty = row_of[shuf_pos];
          col_of[shuf_pos] = col_of[req.swap_index];
          row_of[shuf_pos] = row_of[req.swap_index];
          col_of[req.swap_index] = tx;
          row_of[req.swap_index] = ty;
          shuf_pos++;
        end
      end
      ACT_RESTART: read_pos = 0;
      default: begin
        if (n_cells == 0) begin
          read_pos = 0;
        end else begin
          // A position left past the end by a smaller rebuild starts over at zero.
          if (read_pos >= n_cells) read_pos = 0;
          rsp.cell_x = col_of[read_pos];
          rsp.cell_y = row_of[read_pos];
          read_pos++;
          if (read_pos >= n_cells) read_pos = 0;
        end
      end
    endcase
    rsp.read_position = POS_W'(read_pos);
    return rsp;
  endfunction

  // Offer one request, hold it until the block takes it, then log what it must return.
  task automatic send_request(input action_e act, input logic [SIDX_W-1:0] idx);
    in_req_t req;
    req.action     = act;
    req.swap_index = idx;
    while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_cells.push_back(predict_cell_result(req));
  endtask

  task automatic send_noise();
    send_request(action_e'($urandom_range(3, 0)), SIDX_W'($urandom_range(1023, 0)));
  endtask

  // Drop valid and wait until every owed result is back, then let the clock run on idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_cells.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leave the write enable high; the caller lowers it after the last write.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    if (idx == CFG_COLS) cols_reg = data;
    else rows_reg = data;
    @(posedge clk);
  endtask

  // Reconfigure the grid only once the block has gone idle.
  task automatic set_grid(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
    wait_drained();
    cfg_write(CFG_COLS, cols);
    cfg_write(CFG_ROWS, rows);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly small grids; now and then a border value or any 6-bit value at all.
  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(9, 0))
      0: begin
        case ($urandom_range(4, 0))
          0:       return CFG_W'(0);
          1:       return CFG_W'(1);
          2:       return CFG_W'(32);
          3:       return CFG_W'(33);
          default: return CFG_W'(63);
        endcase
      end
      1:       return CFG_W'($urandom_range(63, 0));
      default: return CFG_W'($urandom_range(6, 1));
    endcase
  endfunction

  // One round on the current grid: build, a full shuffle (capped on large grids), then a
  // readout with restarts. A few stray requests and rejected swaps are mixed in.
  task automatic run_shuffle_round(output int unsigned n_sent);
    int unsigned swaps;
    int unsigned reads;
    int unsigned k;
    n_sent = 0;
    send_request(ACT_BUILD, SIDX_W'($urandom_range(1023, 0)));
    n_sent++;
    swaps = (n_cells < 48) ? n_cells : 48;
    for (k = 0; k < swaps; k++) begin
      if ($urandom_range(19, 0) == 0) send_noise();
      send_request(ACT_SWAP, SIDX_W'($urandom_range(n_cells - 1, 0)));
      n_sent++;
    end
    // Probe the rejection path: an index past the list, or any index, rejected once the shuffle ended.
    if ($urandom_range(3, 0) == 0) begin
      if (n_cells < LIST_SIZE && $urandom_range(1, 0) == 0)
        send_request(ACT_SWAP, SIDX_W'($urandom_range(1023, n_cells)));
      else
        send_request(ACT_SWAP, SIDX_W'($urandom_range(1023, 0)));
    end
    reads = (n_cells + 3 < 40) ? n_cells + 3 : 40;
    for (k = 0; k < reads; k++) begin
      case ($urandom_range(19, 0))
        0:       send_request(ACT_RESTART, SIDX_W'($urandom_range(1023, 0)));
        1:       send_noise();
        default: send_request(ACT_NEXT, SIDX_W'($urandom_range(1023, 0)));
      endcase
      n_sent++;
    end
  endtask

  // Next, swap and restart before any build: empty list, every swap rejected.
  task automatic test_empty_list();
    send_request(ACT_NEXT, '0);
    send_request(ACT_SWAP, '0);
    send_request(ACT_SWAP, '1);
    send_request(ACT_RESTART, '1);
  endtask

  // A 3 by 2 grid: rejected index, full shuffle, swap after the end, readout with wrap.
  task automatic test_small_grid();
    set_grid(CFG_W'(3), CFG_W'(2));
    send_request(ACT_BUILD, '0);
    send_request(ACT_SWAP, SIDX_W'(6));
    send_request(ACT_SWAP, SIDX_W'(5));
    send_request(ACT_SWAP, SIDX_W'(0));
    send_request(ACT_SWAP, SIDX_W'(4));
    send_request(ACT_SWAP, SIDX_W'(3));
    send_request(ACT_SWAP, SIDX_W'(2));
    send_request(ACT_SWAP, SIDX_W'(5));
    send_request(ACT_SWAP, SIDX_W'(0));
    repeat (6) send_request(ACT_NEXT, '0);
    send_request(ACT_RESTART, '0);
  endtask

  // Register counts of zero and past the limit, readout left past the end, full grid.
  task automatic test_grid_extremes();
    set_grid(CFG_W'(0), CFG_W'(63));
    send_request(ACT_BUILD, '0);
    send_request(ACT_NEXT, '0);
    set_grid(CFG_W'(1), CFG_W'(1));
    send_request(ACT_BUILD, '1);
    send_request(ACT_NEXT, '0);
    set_grid(CFG_W'(63), CFG_W'(33));
    send_request(ACT_BUILD, '0);
    send_request(ACT_SWAP, '1);
    send_request(ACT_NEXT, '1);
  endtask

  // Hold off the receiver while requests keep coming, so the block backs up to its input.
  task automatic test_output_hold_off();
    set_grid(CFG_W'(3), CFG_W'(3));
    hold_left = HOLD_CYCLES;
    send_request(ACT_BUILD, '0);
    repeat (9) send_request(ACT_SWAP, SIDX_W'($urandom_range(8, 0)));
    repeat (5) send_request(ACT_NEXT, '0);
    wait_drained();
  endtask

  // A round with no idling on either side.
  task automatic test_calm_stream();
    int unsigned n;
    set_grid(CFG_W'(4), CFG_W'(4));
    calm = 1'b1;
    run_shuffle_round(n);
    wait_drained();
    calm = 1'b0;
  endtask

  task automatic test_random_shuffles(input int unsigned goal);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < goal) begin
      set_grid(pick_dim(), pick_dim());
      run_shuffle_round(n);
      sent += n;
    end
  endtask

  // Compare one result with the oldest owed one, field by field.
  task automatic check_cell_result(input out_rsp_t got);
    out_rsp_t want;
    if (awaited_cells.size() == 0) begin
      $error("result with none owed: %p", got);
      fail_count++;
    end else begin
      want = awaited_cells.pop_front();
      if (got.cell_x !== want.cell_x) begin
        $error("cell_x: expected %0d, got %0d", want.cell_x, got.cell_x);
        fail_count++;
      end
      if (got.cell_y !== want.cell_y) begin
        $error("cell_y: expected %0d, got %0d", want.cell_y, got.cell_y);
        fail_count++;
      end
      if (got.read_position !== want.read_position) begin
        $error("read_position: expected %0d, got %0d", want.read_position,
               got.read_position);
        fail_count++;
      end
      if (got.bad_index !== want.bad_index) begin
        $error("bad_index: expected %0d, got %0d", want.bad_index, got.bad_index);
        fail_count++;
      end
    end
  endtask

  // Receiver: take the result seen at this edge, then pick the stall for the next one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_cell_result(out_rsp);
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99, 0) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[grid_cell_shuffler] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_small_grid();
    test_grid_extremes();
    test_output_hold_off();
    test_calm_stream();
    test_random_shuffles(730);
    wait_drained();
    // Let any stray result show up before the verdict.
    repeat (40) @(posedge clk);
    if (awaited_cells.size() != 0) begin
      $error("%0d results never arrived", awaited_cells.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[grid_cell_shuffler] OK");
    end else begin
      $display("[grid_cell_shuffler] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/gcs_pkg.sv
rtl/core/gcs_list_ram.sv
rtl/core/gcs_ctrl.sv
rtl/core/grid_cell_shuffler.sv
rtl/core/gcs_checker.sv
bench/grid_cell_shuffler_test.sv
